// File: rtl/rat_pkg.sv
package rat_pkg;

    localparam int LEAVES  = 1024;
    localparam int LEVELS  = $clog2(LEAVES);
    localparam int NODES   = 2 * LEAVES;
    localparam int NODE_W  = LEVELS + 1;
    localparam int IDX_W   = 10;
    localparam int LEN_W   = 11;
    localparam int SIZE_W  = 11;
    localparam int VAL_W   = 16;
    localparam int SUM_W   = 27;
    localparam int NUM_W   = 26;
    localparam int SHIFT_W = $clog2(LEVELS + 1);
    localparam int CNT_W   = $clog2(NUM_W);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] tag;
        logic             pend;
    } node_t;

    typedef struct packed {
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [SHIFT_W-1:0] shift;
    } span_t;

    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [LEN_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic             go;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
    } gcd_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] g;
    } gcd_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PUSH,
        ST_QADD,
        ST_UP,
        ST_FIXL,
        ST_FIXR,
        ST_FIXW,
        ST_MOD,
        ST_GCD,
        ST_DIVN,
        ST_DIVD
    } state_t;

    // element span covered by a heap-numbered node
    function automatic span_t node_span(input logic [NODE_W-1:0] n);
        span_t             s;
        int                lvl;
        logic [NODE_W-1:0] idx;
        logic [NODE_W-1:0] base;
        lvl = 0;
        for (int i = 0; i < NODE_W; i++)
        begin
            if (n[i])
            begin
                lvl = i;
            end
        end
        idx     = n & ~(NODE_W'(1) << lvl);
        s.shift = SHIFT_W'(LEVELS - lvl);
        base    = idx << s.shift;
        s.lo    = base[IDX_W-1:0];
        s.hi    = s.lo + IDX_W'((NODE_W'(1) << s.shift) - NODE_W'(1));
        return s;
    endfunction

endpackage

// File: rtl/range_assign_average_tree.sv
// Channel   Transfer when             Carries
// item      start & !busy             op, lo_index, hi_index, value
// result    result_valid (1 cycle)    numerator, denominator
// config    cfg_valid & cfg_ready     cfg_data (array_size)
//
// Tree walk in node RAM: each node visited has read, evaluate and step states, plus a
// push state per tag push or an add state per pending-tag product; each sum fixup as
// an assign climbs back reads the left child, reads the right child and writes back.
// A query then runs a divide, a binary gcd and two more divides.
// After reset and after every config write a clearing pass zeroes the node RAM;
// busy is high meanwhile. Results cannot be stalled.
module range_assign_average_tree (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [rat_pkg::IDX_W-1:0]    lo_index,
    input  logic [rat_pkg::IDX_W-1:0]    hi_index,
    input  logic [rat_pkg::VAL_W-1:0]    value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rat_pkg::SIZE_W-1:0]   cfg_data,
    output logic                         result_valid,
    output logic [rat_pkg::NUM_W-1:0]    numerator,
    output logic [rat_pkg::LEN_W-1:0]    denominator
);

    rat_pkg::state_t                state_reg, state_next;
    logic [rat_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [rat_pkg::NODE_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                           strobe_reg, strobe_next;
    logic                           op_reg, op_next;
    logic [rat_pkg::IDX_W-1:0]      lo_reg, lo_next;
    logic [rat_pkg::IDX_W-1:0]      hi_reg, hi_next;
    logic [rat_pkg::VAL_W-1:0]      val_reg, val_next;
    logic [rat_pkg::VAL_W-1:0]      tag_reg, tag_next;
    logic [rat_pkg::NODE_W-1:0]     node_reg, node_next;
    logic [rat_pkg::NUM_W-1:0]      acc_reg, acc_next;
    logic [rat_pkg::NUM_W-1:0]      prod_reg, prod_next;
    logic [rat_pkg::SUM_W-1:0]      left_reg, left_next;
    logic [rat_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [rat_pkg::LEN_W-1:0]      g_reg, g_next;
    logic [rat_pkg::NUM_W-1:0]      num_reg, num_next;
    logic [rat_pkg::LEN_W-1:0]      den_reg, den_next;

    logic                           ram_we;
    logic [rat_pkg::NODE_W-1:0]     ram_waddr;
    rat_pkg::node_t                 ram_wdata;
    logic [rat_pkg::NODE_W-1:0]     ram_raddr;
    rat_pkg::node_t                 ram_rdata;

    rat_pkg::div_req_t              div_req;
    rat_pkg::div_rsp_t              div_rsp;
    rat_pkg::gcd_req_t              gcd_req;
    rat_pkg::gcd_rsp_t              gcd_rsp;

    rat_pkg::span_t                 sp;
    logic [rat_pkg::IDX_W-1:0]      ov_lo;
    logic [rat_pkg::IDX_W-1:0]      ov_hi;
    logic [rat_pkg::LEN_W-1:0]      ov_len;
    logic [rat_pkg::NODE_W-1:0]     left_child;
    logic [rat_pkg::NODE_W-1:0]     right_child;
    logic [rat_pkg::SHIFT_W-1:0]    child_shift;

    rat_ram #(
        .WIDTH ($bits(rat_pkg::node_t)),
        .DEPTH (rat_pkg::NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rat_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (gcd_req),
        .rsp   (gcd_rsp)
    );

    assign sp          = rat_pkg::node_span(node_reg);
    assign ov_lo       = (lo_reg > sp.lo) ? lo_reg : sp.lo;
    assign ov_hi       = (hi_reg < sp.hi) ? hi_reg : sp.hi;
    assign ov_len      = rat_pkg::LEN_W'({1'b0, ov_hi} - {1'b0, ov_lo})
                         + rat_pkg::LEN_W'(1);
    assign left_child  = {node_reg[rat_pkg::NODE_W-2:0], 1'b0};
    assign right_child = {node_reg[rat_pkg::NODE_W-2:0], 1'b1};
    assign child_shift = sp.shift - rat_pkg::SHIFT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        size_next    = size_reg;
        clr_cnt_next = clr_cnt_reg;
        strobe_next  = 1'b0;
        op_next      = op_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        val_next     = val_reg;
        tag_next     = tag_reg;
        node_next    = node_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        g_next       = g_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        ram_we       = 1'b0;
        ram_waddr    = node_reg;
        ram_wdata    = '0;
        ram_raddr    = node_reg;
        div_req      = '0;
        gcd_req      = '0;

        case (state_reg)
            rat_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + rat_pkg::NODE_W'(1);
                if (clr_cnt_reg == rat_pkg::NODE_W'(rat_pkg::NODES - 1))
                begin
                    state_next = rat_pkg::ST_IDLE;
                end
            end
            rat_pkg::ST_IDLE:
            begin
                if (start && !(lo_index > hi_index)
                    && ({1'b0, hi_index} < size_reg))
                begin
                    op_next    = op;
                    lo_next    = lo_index;
                    hi_next    = hi_index;
                    val_next   = value;
                    len_next   = rat_pkg::LEN_W'({1'b0, hi_index} - {1'b0, lo_index})
                                 + rat_pkg::LEN_W'(1);
                    node_next  = rat_pkg::NODE_W'(1);
                    acc_next   = '0;
                    state_next = rat_pkg::ST_READ;
                end
            end
            rat_pkg::ST_READ:
            begin
                state_next = rat_pkg::ST_EVAL;
            end
            rat_pkg::ST_EVAL:
            begin
                if (lo_reg > sp.hi || hi_reg < sp.lo)
                begin
                    state_next = rat_pkg::ST_UP;
                end
                else if (lo_reg <= sp.lo && hi_reg >= sp.hi)
                begin
                    if (op_reg == rat_pkg::OP_QUERY)
                    begin
                        acc_next = acc_reg + ram_rdata.sum[rat_pkg::NUM_W-1:0];
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.sum  = rat_pkg::SUM_W'(val_reg) << sp.shift;
                        ram_wdata.tag  = val_reg;
                        ram_wdata.pend = 1'b1;
                    end
                    state_next = rat_pkg::ST_UP;
                end
                else if (op_reg == rat_pkg::OP_QUERY)
                begin
                    if (ram_rdata.pend)
                    begin
                        prod_next  = rat_pkg::NUM_W'(rat_pkg::SUM_W'(ram_rdata.tag)
                                     * rat_pkg::SUM_W'(ov_len));
                        state_next = rat_pkg::ST_QADD;
                    end
                    else
                    begin
                        node_next  = left_child;
                        state_next = rat_pkg::ST_READ;
                    end
                end
                else if (ram_rdata.pend)
                begin
                    tag_next       = ram_rdata.tag;
                    ram_we         = 1'b1;
                    ram_waddr      = left_child;
                    ram_wdata.sum  = rat_pkg::SUM_W'(ram_rdata.tag) << child_shift;
                    ram_wdata.tag  = ram_rdata.tag;
                    ram_wdata.pend = 1'b1;
                    state_next     = rat_pkg::ST_PUSH;
                end
                else
                begin
                    node_next  = left_child;
                    state_next = rat_pkg::ST_READ;
                end
            end
            rat_pkg::ST_PUSH:
            begin
                ram_we         = 1'b1;
                ram_waddr      = right_child;
                ram_wdata.sum  = rat_pkg::SUM_W'(tag_reg) << child_shift;
                ram_wdata.tag  = tag_reg;
                ram_wdata.pend = 1'b1;
                node_next      = left_child;
                state_next     = rat_pkg::ST_READ;
            end
            rat_pkg::ST_QADD:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = rat_pkg::ST_UP;
            end
            rat_pkg::ST_UP:
            begin
                if (node_reg == rat_pkg::NODE_W'(1))
                begin
                    if (op_reg == rat_pkg::OP_QUERY)
                    begin
                        div_req.go       = 1'b1;
                        div_req.dividend = acc_reg;
                        div_req.divisor  = len_reg;
                        state_next       = rat_pkg::ST_MOD;
                    end
                    else
                    begin
                        state_next = rat_pkg::ST_IDLE;
                    end
                end
                else if (!node_reg[0])
                begin
                    node_next  = node_reg + rat_pkg::NODE_W'(1);
                    state_next = rat_pkg::ST_READ;
                end
                else
                begin
                    node_next = node_reg >> 1;
                    if (op_reg == rat_pkg::OP_ASSIGN)
                    begin
                        state_next = rat_pkg::ST_FIXL;
                    end
                end
            end
            rat_pkg::ST_FIXL:
            begin
                ram_raddr  = left_child;
                state_next = rat_pkg::ST_FIXR;
            end
            rat_pkg::ST_FIXR:
            begin
                ram_raddr  = right_child;
                left_next  = ram_rdata.sum;
                state_next = rat_pkg::ST_FIXW;
            end
            rat_pkg::ST_FIXW:
            begin
                ram_we        = 1'b1;
                ram_wdata.sum = left_reg + ram_rdata.sum;
                state_next    = rat_pkg::ST_UP;
            end
            rat_pkg::ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    gcd_req.go = 1'b1;
                    gcd_req.a  = len_reg;
                    gcd_req.b  = div_rsp.rem;
                    state_next = rat_pkg::ST_GCD;
                end
            end
            rat_pkg::ST_GCD:
            begin
                if (gcd_rsp.done)
                begin
                    g_next           = gcd_rsp.g;
                    div_req.go       = 1'b1;
                    div_req.dividend = acc_reg;
                    div_req.divisor  = gcd_rsp.g;
                    state_next       = rat_pkg::ST_DIVN;
                end
            end
            rat_pkg::ST_DIVN:
            begin
                if (div_rsp.done)
                begin
                    num_next         = div_rsp.quot;
                    div_req.go       = 1'b1;
                    div_req.dividend = rat_pkg::NUM_W'(len_reg);
                    div_req.divisor  = g_reg;
                    state_next       = rat_pkg::ST_DIVD;
                end
            end
            rat_pkg::ST_DIVD:
            begin
                if (div_rsp.done)
                begin
                    den_next    = div_rsp.quot[rat_pkg::LEN_W-1:0];
                    strobe_next = 1'b1;
                    state_next  = rat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rat_pkg::ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            size_next    = cfg_data;
            clr_cnt_next = '0;
            state_next   = rat_pkg::ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rat_pkg::ST_CLEAR;
            size_reg    <= rat_pkg::SIZE_RESET;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        val_reg  <= val_next;
        tag_reg  <= tag_next;
        node_reg <= node_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        left_reg <= left_next;
        len_reg  <= len_next;
        g_reg    <= g_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
    end

    assign busy         = (state_reg != rat_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = strobe_reg;
    assign numerator    = num_reg;
    assign denominator  = den_reg;

endmodule

// File: rtl/rat_ram.sv
module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/rat_div.sv
module rat_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rat_pkg::div_req_t req,
    output rat_pkg::div_rsp_t rsp
);

    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [rat_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [rat_pkg::NUM_W-1:0]    quo_reg, quo_next;
    logic [rat_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [rat_pkg::LEN_W-1:0]    dvs_reg, dvs_next;
    logic [rat_pkg::LEN_W:0]      rem_sh;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[rat_pkg::NUM_W-1]};
        if (req.go)
        begin
            run_next = 1'b1;
            cnt_next = rat_pkg::CNT_W'(rat_pkg::NUM_W - 1);
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_sh   = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[rat_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[rat_pkg::NUM_W-2:0], 1'b0};
            end
            rem_next = rem_sh[rat_pkg::LEN_W-1:0];
            cnt_next = cnt_reg - rat_pkg::CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: rtl/rat_gcd.sv
module rat_gcd (
    input  logic              clk,
    input  logic              rst_n,
    input  rat_pkg::gcd_req_t req,
    output rat_pkg::gcd_rsp_t rsp
);

    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [rat_pkg::LEN_W-1:0]   a_reg, a_next;
    logic [rat_pkg::LEN_W-1:0]   b_reg, b_next;
    logic [rat_pkg::SHIFT_W-1:0] k_reg, k_next;
    logic [rat_pkg::LEN_W-1:0]   g_reg, g_next;

    // binary gcd, one step per cycle
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (req.go)
        begin
            run_next = 1'b1;
            a_next   = req.a;
            b_next   = req.b;
            k_next   = '0;
        end
        else if (run_reg)
        begin
            if (a_reg == '0)
            begin
                g_next    = b_reg << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                g_next    = a_reg << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + rat_pkg::SHIFT_W'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign rsp.done = done_reg;
    assign rsp.g    = g_reg;

endmodule
